// ===== design/rfpwd_pkg.sv =====
// ----------------------------------------------------------------------------
// rfpwd_pkg
// Shared types and constants of the remote pulse-width decoder.
// ----------------------------------------------------------------------------
package rfpwd_pkg;

	localparam int PACKET_BITS_DEF = 25;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int REG_WIDTH   = 16;
	localparam int CFG_INDEX_W = 3;

	localparam logic [REG_WIDTH-1:0] GAP_RESET      = 16'd70;
	localparam logic [REG_WIDTH-1:0] ZERO_MIN_RESET = 16'd16;
	localparam logic [REG_WIDTH-1:0] ZERO_MAX_RESET = 16'd25;
	localparam logic [REG_WIDTH-1:0] ONE_MIN_RESET  = 16'd51;
	localparam logic [REG_WIDTH-1:0] ONE_MAX_RESET  = 16'd62;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_FLUSH = 2'd2
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GAP      = 3'd0,
		REG_ZERO_MIN = 3'd1,
		REG_ZERO_MAX = 3'd2,
		REG_ONE_MIN  = 3'd3,
		REG_ONE_MAX  = 3'd4
	} reg_index_t;

endpackage

// ===== design/rf_remote_pulse_width_decoder.sv =====
// ----------------------------------------------------------------------------
// rf_remote_pulse_width_decoder
// Decodes a sampled on-off-keyed receiver line into fixed-length packets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: opcode
//   selects a sample tick (with pin_level), a host read or a host flush.
//   Output channel (out_valid / out_stall) returns exactly one word per input
//   word, in order: packet_ready, read_valid, read_data, receiving.
//   The word is captured in the input register when accepted; the decode
//   logic then updates the state and loads the result register as the word
//   moves on. Throughput is one word per cycle while the output is not
//   stalled; the decode step is a handful of compares, a saturating
//   increment and a one-hot bit set.
//   When the receiver stalls, the result register holds its word; the input
//   register still takes one more word, then in_stall rises until the result
//   is taken.
//   Reset loads the timing registers with their defaults and clears counters,
//   reception, the held packet and the ready flag. Timing registers are
//   written through cfg_we / cfg_index / cfg_data. The user must write them
//   only while no word is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module rf_remote_pulse_width_decoder #(
	parameter int PACKET_BITS = rfpwd_pkg::PACKET_BITS_DEF,
	parameter int COUNT_WIDTH = rfpwd_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rfpwd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rfpwd_pkg::REG_WIDTH-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic                              pin_level,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              packet_ready,
	output logic                              read_valid,
	output logic [PACKET_BITS-1:0]            read_data,
	output logic                              receiving
);

	localparam int BC_W  = $clog2(PACKET_BITS + 1);
	localparam int CMP_W = (COUNT_WIDTH > rfpwd_pkg::REG_WIDTH) ?
		COUNT_WIDTH : rfpwd_pkg::REG_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [BC_W-1:0] BC_FULL = BC_W'(PACKET_BITS);

	// timing registers
	logic [rfpwd_pkg::REG_WIDTH-1:0] gap_q, zero_min_q, zero_max_q, one_min_q, one_max_q;

	// decoder state
	logic [COUNT_WIDTH-1:0] tick_q;
	logic                   last_q;
	logic                   armed_q;
	logic [BC_W-1:0]        bc_q;
	logic [PACKET_BITS-1:0] shift_q;
	logic [PACKET_BITS-1:0] held_q;
	logic                   ready_q;

	// input stage
	logic                   valid_s1;
	rfpwd_pkg::opcode_t     op_s1;
	logic                   level_s1;

	// result stage
	logic                   valid_s2;
	logic                   ready_s2;
	logic                   rvalid_s2;
	logic [PACKET_BITS-1:0] rdata_s2;
	logic                   armed_s2;

	logic move;
	logic take;

	assign move     = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !move;
	assign take     = in_valid && !in_stall;

	// next-state logic
	logic [COUNT_WIDTH-1:0] tc_inc;
	logic [CMP_W-1:0]       tc_x;
	logic                   over_gap, in_one, in_zero;
	logic [BC_W-1:0]        pos;
	logic [COUNT_WIDTH-1:0] n_tick;
	logic                   n_last, n_armed, n_ready;
	logic [BC_W-1:0]        n_bc;
	logic [PACKET_BITS-1:0] n_shift, n_held;
	logic                   n_rvalid;
	logic [PACKET_BITS-1:0] n_rdata;
	logic                   ended;

	always_comb begin
		tc_inc   = (tick_q == COUNT_MAX) ? tick_q : tick_q + 1'b1;
		tc_x     = CMP_W'(tc_inc);
		over_gap = tc_x > CMP_W'(gap_q);
		in_one   = (tc_x > CMP_W'(one_min_q)) && (tc_x < CMP_W'(one_max_q));
		in_zero  = (tc_x > CMP_W'(zero_min_q)) && (tc_x < CMP_W'(zero_max_q));
		pos      = BC_FULL - bc_q - 1'b1;

		n_tick   = tick_q;
		n_last   = last_q;
		n_armed  = armed_q;
		n_ready  = ready_q;
		n_bc     = bc_q;
		n_shift  = shift_q;
		n_held   = held_q;
		n_rvalid = 1'b0;
		n_rdata  = '0;
		ended    = 1'b0;

		case (op_s1)
			rfpwd_pkg::OP_TICK: begin
				n_tick = tc_inc;
				if (armed_q) begin
					if (!level_s1 && over_gap) begin
						// end of frame
						n_armed = 1'b0;
						if (bc_q == BC_FULL) begin
							n_held  = shift_q;
							n_ready = 1'b1;
						end
						n_shift = '0;
						n_bc    = '0;
						n_last  = 1'b0;
						n_tick  = '0;
						ended   = 1'b1;
					end else if (!level_s1 && last_q) begin
						if (bc_q >= BC_FULL) begin
							n_armed = 1'b0;
							n_bc    = '0;
							n_shift = '0;
						end else if (in_one) begin
							n_shift = shift_q | (PACKET_BITS'(1) << pos);
							n_bc    = bc_q + 1'b1;
						end else if (in_zero) begin
							n_bc = bc_q + 1'b1;
						end else begin
							n_armed = 1'b0;
							n_bc    = '0;
							n_shift = '0;
						end
					end
				end
				if (!ended && (level_s1 != last_q)) begin
					if (!last_q && over_gap) begin
						n_armed = 1'b1;
					end
					n_last = level_s1;
					n_tick = '0;
				end
			end
			rfpwd_pkg::OP_READ: begin
				if (ready_q) begin
					n_rvalid = 1'b1;
					n_rdata  = held_q;
					n_held   = '0;
					n_ready  = 1'b0;
				end
			end
			rfpwd_pkg::OP_FLUSH: begin
				n_held  = '0;
				n_shift = '0;
				n_bc    = '0;
				n_last  = 1'b0;
				n_tick  = '0;
			end
			default: begin
			end
		endcase
	end

	// control, state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q      <= rfpwd_pkg::GAP_RESET;
			zero_min_q <= rfpwd_pkg::ZERO_MIN_RESET;
			zero_max_q <= rfpwd_pkg::ZERO_MAX_RESET;
			one_min_q  <= rfpwd_pkg::ONE_MIN_RESET;
			one_max_q  <= rfpwd_pkg::ONE_MAX_RESET;
			tick_q     <= '0;
			last_q     <= 1'b0;
			armed_q    <= 1'b0;
			bc_q       <= '0;
			shift_q    <= '0;
			held_q     <= '0;
			ready_q    <= 1'b0;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rfpwd_pkg::REG_GAP:      gap_q      <= cfg_data;
					rfpwd_pkg::REG_ZERO_MIN: zero_min_q <= cfg_data;
					rfpwd_pkg::REG_ZERO_MAX: zero_max_q <= cfg_data;
					rfpwd_pkg::REG_ONE_MIN:  one_min_q  <= cfg_data;
					rfpwd_pkg::REG_ONE_MAX:  one_max_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (move) begin
				tick_q  <= n_tick;
				last_q  <= n_last;
				armed_q <= n_armed;
				bc_q    <= n_bc;
				shift_q <= n_shift;
				held_q  <= n_held;
				ready_q <= n_ready;
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// word payload
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1    <= rfpwd_pkg::opcode_t'(opcode);
			level_s1 <= pin_level;
		end
		if (move) begin
			ready_s2  <= n_ready;
			rvalid_s2 <= n_rvalid;
			rdata_s2  <= n_rdata;
			armed_s2  <= n_armed;
		end
	end

	assign out_valid    = valid_s2;
	assign packet_ready = ready_s2;
	assign read_valid   = rvalid_s2;
	assign read_data    = rdata_s2;
	assign receiving    = armed_s2;

	a_read_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rvalid_s2 |-> !ready_s2)
		else $error("ready flag still set after a packet was handed out");

	a_no_read_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rvalid_s2 |-> rdata_s2 == '0)
		else $error("read data not zero without a handed-out packet");

	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bc_q <= BC_FULL)
		else $error("bit count beyond packet length");

	a_idle_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!armed_q |-> bc_q == '0 && shift_q == '0)
		else $error("frame bits left over while not receiving");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked word");

endmodule

// ===== test/rf_remote_pulse_width_decoder_test.sv =====
// ----------------------------------------------------------------------------
// rf_remote_pulse_width_decoder_test
// Self-checking bench for the remote pulse-width decoder. A short table of
// words runs first, then noise under extreme timing settings and random
// frames built from the bit windows: full packets, short and long frames,
// bad periods, overwrites, reads and flushes. Every result word is checked
// against a cycle-free model of the decoder, or against the table's own
// expectation for the typed rows, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rf_remote_pulse_width_decoder_test;

	localparam int PKT_BITS = rfpwd_pkg::PACKET_BITS_DEF;
	localparam int QUIET_LIMIT = 1000;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic                packet_ready;
		logic                read_valid;
		logic [PKT_BITS-1:0] read_data;
		logic                receiving;
	} decoder_word_t;

	typedef struct packed {
		logic [1:0]    op;
		logic          level;
		logic          typed_in;
		decoder_word_t want;
	} stim_row_t;

	localparam decoder_word_t NO_WORD = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rfpwd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [rfpwd_pkg::REG_WIDTH-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = rfpwd_pkg::OP_TICK;
	logic pin_level = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic packet_ready;
	logic read_valid;
	logic [PKT_BITS-1:0] read_data;
	logic receiving;

	// expectation attached to the word on the input port
	logic load_typed = 1'b0;
	decoder_word_t load_word = '0;

	// decoder model state
	logic [rfpwd_pkg::REG_WIDTH-1:0] cfg_gap = rfpwd_pkg::GAP_RESET;
	logic [rfpwd_pkg::REG_WIDTH-1:0] cfg_zero_min = rfpwd_pkg::ZERO_MIN_RESET;
	logic [rfpwd_pkg::REG_WIDTH-1:0] cfg_zero_max = rfpwd_pkg::ZERO_MAX_RESET;
	logic [rfpwd_pkg::REG_WIDTH-1:0] cfg_one_min = rfpwd_pkg::ONE_MIN_RESET;
	logic [rfpwd_pkg::REG_WIDTH-1:0] cfg_one_max = rfpwd_pkg::ONE_MAX_RESET;
	logic [rfpwd_pkg::COUNT_WIDTH_DEF-1:0] line_ticks = '0;
	logic line_level = 1'b0;
	logic rx_armed = 1'b0;
	logic [4:0] rx_bits = '0;
	logic [PKT_BITS-1:0] rx_shift = '0;
	logic [PKT_BITS-1:0] held_word = '0;
	logic held_ready = 1'b0;

	decoder_word_t pending_words[$];
	decoder_word_t seen_word;
	decoder_word_t due_word;
	int unsigned mismatches = 0;
	int quiet_cycles = 0;
	int idle_max = 4;
	logic hold_request = 1'b0;

	stim_row_t directed_rows [18] = '{
		{rfpwd_pkg::OP_READ,  1'b0, 1'b1, NO_WORD},
		{rfpwd_pkg::OP_FLUSH, 1'b0, 1'b1, NO_WORD},
		{OP_SPARE,            1'b1, 1'b1, NO_WORD},
		{OP_SPARE,            1'b0, 1'b1, NO_WORD},
		{rfpwd_pkg::OP_TICK,  1'b1, 1'b1, NO_WORD},
		{rfpwd_pkg::OP_TICK,  1'b1, 1'b1, NO_WORD},
		{rfpwd_pkg::OP_TICK,  1'b0, 1'b1, NO_WORD},
		{rfpwd_pkg::OP_READ,  1'b1, 1'b1, NO_WORD},
		{rfpwd_pkg::OP_TICK,  1'b1, 1'b0, NO_WORD},
		{rfpwd_pkg::OP_FLUSH, 1'b1, 1'b0, NO_WORD},
		{rfpwd_pkg::OP_TICK,  1'b1, 1'b0, NO_WORD},
		{rfpwd_pkg::OP_TICK,  1'b0, 1'b0, NO_WORD},
		{rfpwd_pkg::OP_TICK,  1'b0, 1'b0, NO_WORD},
		{rfpwd_pkg::OP_READ,  1'b0, 1'b0, NO_WORD},
		{OP_SPARE,            1'b1, 1'b0, NO_WORD},
		{rfpwd_pkg::OP_TICK,  1'b1, 1'b0, NO_WORD},
		{rfpwd_pkg::OP_FLUSH, 1'b0, 1'b0, NO_WORD},
		{rfpwd_pkg::OP_TICK,  1'b0, 1'b0, NO_WORD}
	};

	rf_remote_pulse_width_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.pin_level(pin_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.packet_ready(packet_ready),
		.read_valid(read_valid),
		.read_data(read_data),
		.receiving(receiving)
	);

	always #5 clk = ~clk;

	function automatic void sample_line(input logic level);
		if (line_ticks != '1)
			line_ticks++;
		if (rx_armed) begin
			if (!level && line_ticks > cfg_gap) begin
				rx_armed = 1'b0;
				if (rx_bits == PKT_BITS) begin
					held_word = rx_shift;
					held_ready = 1'b1;
				end
				rx_shift = '0;
				rx_bits = '0;
				line_level = 1'b0;
				line_ticks = '0;
				return;
			end
			if (!level && line_level) begin
				if (rx_bits >= PKT_BITS) begin
					rx_armed = 1'b0;
					rx_bits = '0;
					rx_shift = '0;
				end else if (line_ticks > cfg_one_min && line_ticks < cfg_one_max) begin
					rx_shift[PKT_BITS-1-rx_bits] = 1'b1;
					rx_bits++;
				end else if (line_ticks > cfg_zero_min && line_ticks < cfg_zero_max) begin
					rx_bits++;
				end else begin
					rx_armed = 1'b0;
					rx_bits = '0;
					rx_shift = '0;
				end
			end
		end
		if (level != line_level) begin
			if (!line_level && line_ticks > cfg_gap)
				rx_armed = 1'b1;
			line_level = level;
			line_ticks = '0;
		end
	endfunction

	function automatic decoder_word_t step_decoder(input logic [1:0] op, input logic level);
		decoder_word_t word;
		word = '0;
		case (op)
			rfpwd_pkg::OP_TICK: sample_line(level);
			rfpwd_pkg::OP_READ: begin
				if (held_ready) begin
					word.read_valid = 1'b1;
					word.read_data = held_word;
					held_word = '0;
					held_ready = 1'b0;
				end
			end
			rfpwd_pkg::OP_FLUSH: begin
				held_word = '0;
				rx_shift = '0;
				rx_bits = '0;
				line_level = 1'b0;
				line_ticks = '0;
			end
			default: ;
		endcase
		word.packet_ready = held_ready;
		word.receiving = rx_armed;
		return word;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// scoreboard: predict on input words, check on result words
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				due_word = step_decoder(opcode, pin_level);
				pending_words.push_back(load_typed ? load_word : due_word);
			end
			if (out_valid && !out_stall) begin
				seen_word = {packet_ready, read_valid, read_data, receiving};
				if (pending_words.size() == 0) begin
					report_mismatch("result word with none expected", 32'(seen_word), 32'd0);
				end else begin
					due_word = pending_words.pop_front();
					if (seen_word.packet_ready !== due_word.packet_ready)
						report_mismatch("packet_ready", 32'(seen_word.packet_ready),
							32'(due_word.packet_ready));
					if (seen_word.read_valid !== due_word.read_valid)
						report_mismatch("read_valid", 32'(seen_word.read_valid),
							32'(due_word.read_valid));
					if (seen_word.read_data !== due_word.read_data)
						report_mismatch("read_data", 32'(seen_word.read_data),
							32'(due_word.read_data));
					if (seen_word.receiving !== due_word.receiving)
						report_mismatch("receiving", 32'(seen_word.receiving),
							32'(due_word.receiving));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("rf_remote_pulse_width_decoder regression: fail");
			$finish;
		end
	end

	// result side stalls
	initial begin
		int stall_cycles;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_cycles = 50;
			end else begin
				stall_cycles = $urandom_range(0, idle_max);
			end
			if (stall_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (stall_cycles) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid && !out_stall))
				@(posedge clk);
		end
	end

	task automatic send_item(input logic [1:0] op, input logic level, input logic typed_in,
			input decoder_word_t want);
		int wait_cycles;
		wait_cycles = $urandom_range(0, idle_max);
		if (wait_cycles > 0) begin
			in_valid <= 1'b0;
			repeat (wait_cycles) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		pin_level <= level;
		load_typed <= typed_in;
		load_word <= want;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drive_level(input logic level, input int count);
		repeat (count)
			send_item(rfpwd_pkg::OP_TICK, level, 1'b0, NO_WORD);
	endtask

	task automatic send_noise(input int count);
		logic [1:0] op;
		repeat (count) begin
			op = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 7) < 4)
				op = rfpwd_pkg::OP_TICK;
			send_item(op, 1'($urandom_range(0, 1)), 1'b0, NO_WORD);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_timing(input logic [rfpwd_pkg::REG_WIDTH-1:0] gap, zmin, zmax,
			omin, omax);
		logic [rfpwd_pkg::REG_WIDTH-1:0] values [5];
		drain_results();
		repeat (4) @(negedge clk);
		values = '{gap, zmin, zmax, omin, omax};
		for (int i = rfpwd_pkg::REG_GAP; i <= rfpwd_pkg::REG_ONE_MAX; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= rfpwd_pkg::reg_index_t'(i);
			cfg_data <= values[i];
			@(negedge clk);
		end
		// index past the register list, must be ignored
		cfg_we <= 1'b1;
		cfg_index <= rfpwd_pkg::REG_ONE_MAX + 3'($urandom_range(1, 3));
		cfg_data <= 16'($urandom_range(0, 65535));
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_gap = gap;
		cfg_zero_min = zmin;
		cfg_zero_max = zmax;
		cfg_one_min = omin;
		cfg_one_max = omax;
		@(negedge clk);
	endtask

	function automatic int pick_period(input logic [rfpwd_pkg::REG_WIDTH-1:0] lo_excl,
			input logic [rfpwd_pkg::REG_WIDTH-1:0] hi_excl);
		int lo, hi;
		lo = int'(lo_excl) + 1;
		hi = int'(hi_excl) - 1;
		if (lo < 1)
			lo = 1;
		if (hi < lo)
			hi = lo;
		return $urandom_range(lo, hi);
	endfunction

	task automatic run_frames(input int count);
		int kind, nbits, bad_at, period, spare_lows, after;
		repeat (count) begin
			idle_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			kind = $urandom_range(0, 9);
			nbits = PKT_BITS;
			bad_at = -1;
			if (kind == 6)
				nbits = $urandom_range(1, PKT_BITS - 1);
			else if (kind == 7)
				nbits = PKT_BITS + $urandom_range(1, 2);
			else if (kind == 8)
				bad_at = $urandom_range(0, PKT_BITS - 1);
			spare_lows = (cfg_gap < 2) ? int'(cfg_gap) : 2;
			if (kind == 9) begin
				send_noise($urandom_range(10, 30));
			end else begin
				drive_level(1'b0, int'(cfg_gap) + 2 + $urandom_range(0, 2));
				for (int b = 0; b < nbits; b++) begin
					if (b == bad_at)
						period = ((cfg_zero_max > cfg_one_max) ? int'(cfg_zero_max) :
							int'(cfg_one_max)) + $urandom_range(0, 2);
					else if ($urandom_range(0, 1) != 0)
						period = pick_period(cfg_one_min, cfg_one_max);
					else
						period = pick_period(cfg_zero_min, cfg_zero_max);
					drive_level(1'b1, period);
					// broken sequence: host access in the middle of a bit
					if ($urandom_range(0, 59) == 0)
						send_item(($urandom_range(0, 1) != 0) ? rfpwd_pkg::OP_READ :
							rfpwd_pkg::OP_FLUSH, 1'b1, 1'b0, NO_WORD);
					drive_level(1'b0, 1 + $urandom_range(0, spare_lows));
				end
				drive_level(1'b0, int'(cfg_gap) + 1 + $urandom_range(0, 1));
			end
			after = $urandom_range(0, 9);
			if (after == 6)
				send_item(rfpwd_pkg::OP_FLUSH, 1'b0, 1'b0, NO_WORD);
			if (after <= 6)
				send_item(rfpwd_pkg::OP_READ, 1'($urandom_range(0, 1)), 1'b0, NO_WORD);
		end
		idle_max = 4;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r])
			send_item(directed_rows[r].op, directed_rows[r].level, directed_rows[r].typed_in,
				directed_rows[r].want);

		program_timing('0, '0, '0, '0, '0);
		send_noise(60);
		program_timing('1, '1, '1, '1, '1);
		send_noise(60);

		program_timing(16'd3, 16'd0, 16'd2, 16'd1, 16'd4);
		hold_request = 1'b1;
		run_frames(4);
		// overlapping windows
		program_timing(16'd4, 16'd0, 16'd3, 16'd1, 16'd4);
		run_frames(4);
		program_timing(16'd6, 16'd1, 16'd4, 16'd4, 16'd8);
		run_frames(3);
		program_timing(rfpwd_pkg::GAP_RESET, rfpwd_pkg::ZERO_MIN_RESET,
			rfpwd_pkg::ZERO_MAX_RESET, rfpwd_pkg::ONE_MIN_RESET, rfpwd_pkg::ONE_MAX_RESET);
		send_noise(40);

		drain_results();
		repeat (8) @(posedge clk);
		if (pending_words.size() != 0)
			report_mismatch("result words never delivered", 32'(pending_words.size()), 32'd0);
		if (mismatches == 0)
			$display("rf_remote_pulse_width_decoder regression: pass");
		else
			$display("rf_remote_pulse_width_decoder regression: fail");
		$finish;
	end

endmodule
